@@ design/ofdm_subcarrier_mapper_unit_assert.svh @@
// assertion macros for the mapper rtl
// clk and arst_n are taken from the module that uses them
`ifndef OFDM_SUBCARRIER_MAPPER_UNIT_ASSERT_SVH
`define OFDM_SUBCARRIER_MAPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define OSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/osm_pkg.sv @@
package osm_pkg;

	localparam int MAX_CELLS    = 4096;
	localparam int SAMPLE_WIDTH = 16;
	localparam int SIZE_W       = 13;
	localparam int GUARD_W      = 11;
	localparam int INDEX_W      = 12;
	localparam int ACC_W        = 26;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 32;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	typedef enum logic [1:0] {
		CELL_GUARD = 2'd0,
		CELL_PILOT = 2'd1,
		CELL_DATA  = 2'd2
	} cell_kind_t;

	typedef enum logic [2:0] {
		REG_SYM_CELLS   = 3'd0,
		REG_GUARD_COUNT = 3'd1,
		REG_PILOT_COUNT = 3'd2,
		REG_PILOT_I     = 3'd3,
		REG_PILOT_Q     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  sym_cells;
		logic [GUARD_W-1:0] guard_count;
		logic [SIZE_W-1:0]  pilot_count;
		// pilot count that a symbol restarted at this edge runs with
		logic [SIZE_W-1:0]  restart_pilots;
		sample_t            pilot_i;
		sample_t            pilot_q;
		logic               restart;
	} osm_cfg_t;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] n);
		if (n == '0)
			return SIZE_W'(1);
		else if (n > SIZE_W'(MAX_CELLS))
			return SIZE_W'(MAX_CELLS);
		else
			return n;
	endfunction

	function automatic logic [SIZE_W-1:0] eff_pilots(input logic [SIZE_W-1:0] p);
		return (p > SIZE_W'(MAX_CELLS)) ? SIZE_W'(MAX_CELLS) : p;
	endfunction

	// pilot target at the start of a symbol: p - 1, or 0 with no pilots
	function automatic logic [ACC_W-1:0] start_target(input logic [SIZE_W-1:0] p);
		return (p == '0) ? '0 : ACC_W'(p - SIZE_W'(1));
	endfunction

endpackage

@@ design/osm_ifs.sv @@
interface osm_in_if import osm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data_i;
	sample_t data_q;
	logic    data_available;

	modport source (output valid, output data_i, output data_q, output data_available,
		input ready);
	modport sink (input valid, input data_i, input data_q, input data_available,
		output ready);
endinterface

interface osm_out_if import osm_pkg::*; ();
	logic       valid;
	logic       ready;
	sample_t    cell_i;
	sample_t    cell_q;
	cell_kind_t cell_kind;
	logic       data_taken;
	logic       symbol_end;

	modport source (output valid, output cell_i, output cell_q, output cell_kind,
		output data_taken, output symbol_end, input ready);
	modport sink (input valid, input cell_i, input cell_q, input cell_kind,
		input data_taken, input symbol_end, output ready);
endinterface

@@ design/osm_cfg_regs.sv @@
module osm_cfg_regs import osm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output osm_cfg_t          cfg
);

	logic [SIZE_W-1:0]  sym_cells_q;
	logic [GUARD_W-1:0] guard_count_q;
	logic [SIZE_W-1:0]  pilot_count_q;
	sample_t            pilot_i_q;
	sample_t            pilot_q_q;
	logic               wr_restart;
	logic               wr_en;
	reg_idx_t           idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_cells_q   <= SIZE_W'(64);
			guard_count_q <= GUARD_W'(4);
			pilot_count_q <= SIZE_W'(8);
			pilot_i_q     <= sample_t'(16384);
			pilot_q_q     <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SYM_CELLS:   sym_cells_q   <= pwdata[SIZE_W-1:0];
				REG_GUARD_COUNT: guard_count_q <= pwdata[GUARD_W-1:0];
				REG_PILOT_COUNT: pilot_count_q <= pwdata[SIZE_W-1:0];
				REG_PILOT_I:     pilot_i_q     <= pwdata[SAMPLE_WIDTH-1:0];
				REG_PILOT_Q:     pilot_q_q     <= pwdata[SAMPLE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// writes past the register list leave the symbol running
	always_comb begin
		wr_restart = 1'b0;
		if (wr_en) begin
			case (idx)
				REG_SYM_CELLS, REG_GUARD_COUNT, REG_PILOT_COUNT,
				REG_PILOT_I, REG_PILOT_Q: wr_restart = 1'b1;
				default:                  wr_restart = 1'b0;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SYM_CELLS:   prdata = DATA_W'(sym_cells_q);
			REG_GUARD_COUNT: prdata = DATA_W'(guard_count_q);
			REG_PILOT_COUNT: prdata = DATA_W'(pilot_count_q);
			REG_PILOT_I:     prdata = DATA_W'(unsigned'(pilot_i_q));
			REG_PILOT_Q:     prdata = DATA_W'(unsigned'(pilot_q_q));
			default:         prdata = '0;
		endcase
	end

	assign cfg.sym_cells      = sym_cells_q;
	assign cfg.guard_count    = guard_count_q;
	assign cfg.pilot_count    = pilot_count_q;
	// a pilot count write restarts the symbol with the value being written
	assign cfg.restart_pilots = (wr_en && (idx == REG_PILOT_COUNT)) ?
		pwdata[SIZE_W-1:0] : pilot_count_q;
	assign cfg.pilot_i        = pilot_i_q;
	assign cfg.pilot_q        = pilot_q_q;
	assign cfg.restart        = wr_restart;

endmodule

@@ design/osm_cell_engine.sv @@
`include "ofdm_subcarrier_mapper_unit_assert.svh"

module osm_cell_engine import osm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  osm_cfg_t   cfg,
	osm_in_if.sink     sym_in,
	osm_out_if.source  cell_out
);

	// input register
	logic    valid_s1;
	sample_t data_i_s1;
	sample_t data_q_s1;
	logic    avail_s1;

	// result register
	logic       valid_s2;
	sample_t    cell_i_s2;
	sample_t    cell_q_s2;
	cell_kind_t cell_kind_s2;
	logic       taken_s2;
	logic       end_s2;

	// symbol walk state
	logic [INDEX_W-1:0] cell_index_q;
	logic [SIZE_W-1:0]  pilot_number_q;
	logic [ACC_W-1:0]   pilot_target_q;
	logic [ACC_W-1:0]   cell_scaled_q;

	logic               in_acc;
	logic               adv;
	logic [SIZE_W-1:0]  n_eff;
	logic [SIZE_W-1:0]  p_eff;
	logic [SIZE_W:0]    c_ext;
	logic [SIZE_W:0]    g_ext;
	logic [SIZE_W:0]    n_ext;
	logic [SIZE_W:0]    c_next;
	logic [SIZE_W:0]    span_x2;
	logic [SIZE_W:0]    pm1_x2;
	logic [ACC_W:0]     scaled_ahead;
	logic               used;
	logic               pilot_hit;
	logic               last_cell;
	sample_t            res_i;
	sample_t            res_q;
	cell_kind_t         res_kind;
	logic               res_taken;
	logic               out_guard;
	logic               out_taken;
	logic               end_adv;

	assign adv          = valid_s1 && (!valid_s2 || cell_out.ready);
	assign sym_in.ready = !valid_s1 || adv;
	assign in_acc       = sym_in.valid && sym_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_acc || (valid_s1 && !adv);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_i_s1 <= sym_in.data_i;
			data_q_s1 <= sym_in.data_q;
			avail_s1  <= sym_in.data_available;
		end
	end

	always_comb begin
		n_eff  = eff_size(cfg.sym_cells);
		p_eff  = eff_pilots(cfg.pilot_count);
		c_ext  = (SIZE_W+1)'(cell_index_q);
		g_ext  = (SIZE_W+1)'(cfg.guard_count);
		n_ext  = (SIZE_W+1)'(n_eff);
		c_next = c_ext + (SIZE_W+1)'(1);
		used   = (c_ext >= g_ext) && (c_ext + g_ext < n_ext);
		// 2*(U-1); only meaningful on a used cell
		span_x2 = (n_ext - (g_ext << 1) - (SIZE_W+1)'(1)) << 1;
		pm1_x2  = (p_eff == '0) ? '0 : ((SIZE_W+1)'(p_eff) - (SIZE_W+1)'(1)) << 1;
		scaled_ahead = (ACC_W+1)'(cell_scaled_q) + (ACC_W+1)'(pm1_x2);
		pilot_hit = used && (pilot_number_q < p_eff) &&
			((p_eff == SIZE_W'(1)) || ((ACC_W+1)'(pilot_target_q) < scaled_ahead));
		last_cell = c_next >= n_ext;

		res_i     = '0;
		res_q     = '0;
		res_taken = 1'b0;
		res_kind  = CELL_GUARD;
		if (pilot_hit) begin
			res_i    = cfg.pilot_i;
			res_q    = cfg.pilot_q;
			res_kind = CELL_PILOT;
		end else if (used) begin
			res_kind = CELL_DATA;
			if (avail_s1) begin
				res_i     = data_i_s1;
				res_q     = data_q_s1;
				res_taken = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_index_q   <= '0;
			pilot_number_q <= '0;
			pilot_target_q <= start_target(SIZE_W'(8));
			cell_scaled_q  <= '0;
		end else if (cfg.restart || (adv && last_cell)) begin
			cell_index_q   <= '0;
			pilot_number_q <= '0;
			pilot_target_q <= start_target(eff_pilots(cfg.restart_pilots));
			cell_scaled_q  <= '0;
		end else if (adv) begin
			cell_index_q <= c_next[INDEX_W-1:0];
			if (pilot_hit) begin
				pilot_number_q <= pilot_number_q + SIZE_W'(1);
				pilot_target_q <= pilot_target_q + ACC_W'(span_x2);
			end
			if (used)
				cell_scaled_q <= cell_scaled_q + ACC_W'(pm1_x2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (cell_out.ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_i_s2    <= res_i;
			cell_q_s2    <= res_q;
			cell_kind_s2 <= res_kind;
			taken_s2     <= res_taken;
			end_s2       <= last_cell;
		end
	end

	assign cell_out.valid      = valid_s2;
	assign cell_out.cell_i     = cell_i_s2;
	assign cell_out.cell_q     = cell_q_s2;
	assign cell_out.cell_kind  = cell_kind_s2;
	assign cell_out.data_taken = taken_s2;
	assign cell_out.symbol_end = end_s2;

	assign out_guard = valid_s2 && (cell_kind_s2 == CELL_GUARD);
	assign out_taken = valid_s2 && taken_s2;
	assign end_adv   = adv && last_cell && !cfg.restart;

	`OSM_ASSERT_NOW(a_taken_is_data, out_taken, cell_kind_s2 == CELL_DATA, "taken off a data cell")
	`OSM_ASSERT_NOW(a_guard_zero, out_guard, {cell_i_s2, cell_q_s2} == '0, "guard cell not zero")
	`OSM_ASSERT_NOW(a_index_in_symbol, 1'b1, c_ext < n_ext, "cell index beyond symbol")
	`OSM_ASSERT_NOW(a_pilot_bound, 1'b1, pilot_number_q <= p_eff, "more pilots than configured")
	`OSM_ASSERT_NEXT(a_end_restarts, end_adv, {cell_index_q, pilot_number_q} == '0, "no restart")

endmodule

@@ design/ofdm_subcarrier_mapper_unit.sv @@
// an accepted request passes the input register, then the result register, before its cell is offered
// throughput: one cell per cycle while cell_out.ready holds, with the pilot position tracked by additions and a compare
// while a cell waits unread, one more request fits in the input register, then input stalls
// reset: arst_n clears valids and restarts the symbol at cell 0, registers take their defaults
// a write to any listed register restarts the symbol with fresh pilot state
module ofdm_subcarrier_mapper_unit import osm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	osm_in_if.sink            sym_in,
	osm_out_if.source         cell_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	osm_cfg_t cfg;

	osm_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	osm_cell_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.sym_in   (sym_in),
		.cell_out (cell_out)
	);

endmodule
